// ===== sv/ssrsd_pkg.sv =====
// Shared types, constants and segment table for the seven-segment relay scan driver.
package ssrsd_pkg;

  localparam int DIGIT_COUNT = 4;
  localparam int POS_W       = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
  localparam int LANES       = 4;
  localparam int MAG_W       = 14;
  localparam int REG_IDX_W   = 3;

  localparam logic [7:0] SEG_BLANK = 8'b0000_0000;
  localparam logic [7:0] SEG_DASH  = 8'b0100_0000;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NUL  = 8'h00;

  localparam logic signed [31:0] NUM_MAX = 32'sd9999;
  localparam logic signed [31:0] NUM_MIN = -32'sd999;

  localparam logic [REG_IDX_W-1:0] REG_RELAY_RESET_ALL_ON  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_DIGIT_SELECT_FIRST  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_DIGIT_SELECT_SECOND = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_DIGIT_SELECT_THIRD  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_DIGIT_SELECT_FOURTH = 3'd4;

  // Reciprocal multipliers and shifts giving mag / 10^(3-p) exactly for mag <= 9999.
  localparam logic [15:0] LANE_RECIP [LANES] = '{16'd8389, 16'd5243, 16'd52429, 16'd1};
  localparam logic [4:0]  LANE_SHIFT [LANES] = '{5'd23, 5'd19, 5'd19, 5'd0};

  typedef enum logic [2:0] {
    CMD_SCAN       = 3'd0,
    CMD_RELAYS_ALL = 3'd1,
    CMD_RELAY_BIT  = 3'd2,
    CMD_TEXT       = 3'd3,
    CMD_NUMBER     = 3'd4
  } cmd_e;

  typedef struct packed {
    logic [MAG_W-1:0] q;
    logic [7:0]       glyph;
    logic             nul;
  } lane_res_t;

  function automatic logic [7:0] glyph(input logic [7:0] ch);
    logic [7:0] seg;
    unique case (ch)
      "0": seg = 8'h3F;
      "1": seg = 8'h06;
      "2": seg = 8'h5B;
      "3": seg = 8'h4F;
      "4": seg = 8'h66;
      "5": seg = 8'h6D;
      "6": seg = 8'h7D;
      "7": seg = 8'h07;
      "8": seg = 8'h7F;
      "9": seg = 8'h6F;
      ".": seg = 8'h80;
      "-": seg = 8'h40;
      "_": seg = 8'h08;
      "A": seg = 8'h77;
      "a": seg = 8'h5F;
      "B", "b": seg = 8'h7C;
      "C": seg = 8'h39;
      "c": seg = 8'h58;
      "D", "d": seg = 8'h5E;
      "E": seg = 8'h79;
      "e": seg = 8'h7B;
      "F", "f": seg = 8'h71;
      "G", "g": seg = 8'h6F;
      "H": seg = 8'h76;
      "h": seg = 8'h74;
      "I": seg = 8'h06;
      "i": seg = 8'h10;
      "J", "j": seg = 8'h1E;
      "L": seg = 8'h38;
      "l": seg = 8'h18;
      "M", "m": seg = 8'h37;
      "N", "n": seg = 8'h54;
      "O", "o": seg = 8'h5C;
      "P", "p": seg = 8'h73;
      "Q", "q": seg = 8'h67;
      "R", "r": seg = 8'h50;
      "S", "s": seg = 8'h6D;
      "T", "t": seg = 8'h78;
      "U": seg = 8'h3E;
      "u": seg = 8'h1C;
      "Y", "y": seg = 8'h66;
      "Z", "z": seg = 8'h5B;
      default: seg = SEG_BLANK;
    endcase
    return seg;
  endfunction

endpackage

// ===== sv/ssrsd_lane.sv =====
// One display position lane: decimal weight quotient and text glyph, registered.
module ssrsd_lane (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [ssrsd_pkg::MAG_W-1:0] mag_i,
  input  logic [15:0]                 recip_i,
  input  logic [4:0]                  shift_i,
  input  logic [7:0]                  char_i,
  output ssrsd_pkg::lane_res_t        res_o
);

  logic [29:0]          prod;
  logic [29:0]          scaled;
  ssrsd_pkg::lane_res_t res_q;

  assign prod   = 30'(mag_i) * 30'(recip_i);
  assign scaled = prod >> shift_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q.q     <= scaled[ssrsd_pkg::MAG_W-1:0];
      res_q.glyph <= ssrsd_pkg::glyph(char_i);
      res_q.nul   <= (char_i == ssrsd_pkg::CHAR_NUL);
    end
  end

  assign res_o = res_q;

endmodule

// ===== sv/ssrsd_merge.sv =====
// Merge of the lane results into the four new segment bytes for text or number.
module ssrsd_merge (
  input  ssrsd_pkg::lane_res_t res_i [ssrsd_pkg::LANES],
  input  logic                 number_i,
  input  logic                 neg_i,
  input  logic                 oor_i,
  output logic [7:0]           seg_o [ssrsd_pkg::LANES]
);

  logic [ssrsd_pkg::MAG_W-1:0] higher [ssrsd_pkg::LANES];
  logic [ssrsd_pkg::MAG_W-1:0] diff   [ssrsd_pkg::LANES];
  logic                        shown  [ssrsd_pkg::LANES];
  logic                        minus  [ssrsd_pkg::LANES];
  logic                        ended  [ssrsd_pkg::LANES];

  always_comb begin
    higher[0] = '0;
    for (int p = 1; p < ssrsd_pkg::LANES; p++) begin
      higher[p] = res_i[p-1].q;
    end
    for (int p = 0; p < ssrsd_pkg::LANES; p++) begin
      diff[p]  = res_i[p].q - ((higher[p] << 3) + (higher[p] << 1));
      shown[p] = (p == ssrsd_pkg::LANES - 1) || (res_i[p].q != '0);
    end
    minus[ssrsd_pkg::LANES-1] = 1'b0;
    for (int p = 0; p < ssrsd_pkg::LANES - 1; p++) begin
      minus[p] = neg_i && !shown[p] && shown[p+1];
    end
    ended[0] = res_i[0].nul;
    for (int p = 1; p < ssrsd_pkg::LANES; p++) begin
      ended[p] = ended[p-1] || res_i[p].nul;
    end
    for (int p = 0; p < ssrsd_pkg::LANES; p++) begin
      if (!number_i) begin
        seg_o[p] = ended[p] ? ssrsd_pkg::SEG_BLANK : res_i[p].glyph;
      end else if (oor_i) begin
        seg_o[p] = (p == 1 || p == 2) ? ssrsd_pkg::SEG_DASH : ssrsd_pkg::SEG_BLANK;
      end else if (shown[p]) begin
        seg_o[p] = ssrsd_pkg::glyph(ssrsd_pkg::CHAR_ZERO + {4'd0, diff[p][3:0]});
      end else if (minus[p]) begin
        seg_o[p] = ssrsd_pkg::SEG_DASH;
      end else begin
        seg_o[p] = ssrsd_pkg::SEG_BLANK;
      end
    end
  end

endmodule

// ===== sv/seven_segment_relay_scan_driver.sv =====
// Top level of the seven-segment relay scan driver: input stage, lanes, state and frame output.
//
//   Channel  Direction  Handshake                      Payload
//   in       sink       in_valid_i / in_stall_o        command, relay and text fields, number
//   out      source     out_valid_o / out_stall_i      frame_relays, digit select, segments
//   cfg      sink       cfg_valid_i / cfg_ready_o      cfg_index_i, cfg_data_i
//
// Each command passes three stages: input capture with range check and magnitude,
// the four position lanes with their reciprocal multipliers, and the merge and state
// update that loads the frame register.
// One command is taken every cycle while the frame register can move.
// Reset clears the relays, the display, the scan position and the last frame bytes.
// A stalled frame holds the whole pipeline and stalls the input channel.
module seven_segment_relay_scan_driver (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  command_i,
  input  logic [7:0]  relay_mask_i,
  input  logic [2:0]  relay_index_i,
  input  logic        relay_level_i,
  input  logic [7:0]  text_char_0_i,
  input  logic [7:0]  text_char_1_i,
  input  logic [7:0]  text_char_2_i,
  input  logic [7:0]  text_char_3_i,
  input  logic signed [31:0] shown_number_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  frame_relays_o,
  output logic [7:0]  frame_digit_select_o,
  output logic [7:0]  frame_segments_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [ssrsd_pkg::REG_IDX_W-1:0] cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  localparam int L = ssrsd_pkg::LANES;

  logic advance;
  logic in_accept;

  logic                        v1_q;
  ssrsd_pkg::cmd_e             cmd1_q;
  logic [7:0]                  mask1_q;
  logic [2:0]                  index1_q;
  logic                        level1_q;
  logic [7:0]                  char1_q [L];
  logic [ssrsd_pkg::MAG_W-1:0] mag1_q;
  logic                        neg1_q;
  logic                        oor1_q;

  logic                        v2_q;
  ssrsd_pkg::cmd_e             cmd2_q;
  logic [7:0]                  mask2_q;
  logic [2:0]                  index2_q;
  logic                        level2_q;
  logic                        neg2_q;
  logic                        oor2_q;

  ssrsd_pkg::lane_res_t        lane_res [L];
  logic [7:0]                  new_seg  [L];

  logic [7:0]                  sel_q [L];
  logic [7:0]                  relay_q, relay_d;
  logic [7:0]                  store_q [L];
  logic [7:0]                  store_d [L];
  logic [ssrsd_pkg::POS_W-1:0] pos_q, pos_d;
  logic [7:0]                  last_sel_q, last_sel_d;
  logic [7:0]                  last_seg_q, last_seg_d;
  logic                        emit;

  logic                        out_valid_q;
  logic [7:0]                  out_relays_q;
  logic [7:0]                  out_sel_q;
  logic [7:0]                  out_seg_q;

  logic [ssrsd_pkg::MAG_W-1:0] mag_in;
  logic                        oor_in;

  assign advance    = !(out_valid_q && out_stall_i);
  assign in_stall_o = !advance;
  assign in_accept  = in_valid_i && advance;

  assign oor_in = (shown_number_i > ssrsd_pkg::NUM_MAX) || (shown_number_i < ssrsd_pkg::NUM_MIN);
  assign mag_in = shown_number_i[31] ? (~shown_number_i[ssrsd_pkg::MAG_W-1:0] + 1'b1)
                                     : shown_number_i[ssrsd_pkg::MAG_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (advance) begin
      v1_q <= in_accept;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      cmd1_q     <= ssrsd_pkg::cmd_e'(command_i);
      mask1_q    <= relay_mask_i;
      index1_q   <= relay_index_i;
      level1_q   <= relay_level_i;
      char1_q[0] <= text_char_0_i;
      char1_q[1] <= text_char_1_i;
      char1_q[2] <= text_char_2_i;
      char1_q[3] <= text_char_3_i;
      mag1_q     <= mag_in;
      neg1_q     <= shown_number_i[31];
      oor1_q     <= oor_in;
      cmd2_q     <= cmd1_q;
      mask2_q    <= mask1_q;
      index2_q   <= index1_q;
      level2_q   <= level1_q;
      neg2_q     <= neg1_q;
      oor2_q     <= oor1_q;
    end
  end

  for (genvar p = 0; p < L; p++) begin : g_lane
    ssrsd_lane u_lane (
      .clk_i   (clk_i),
      .en_i    (advance),
      .mag_i   (mag1_q),
      .recip_i (ssrsd_pkg::LANE_RECIP[p]),
      .shift_i (ssrsd_pkg::LANE_SHIFT[p]),
      .char_i  (char1_q[p]),
      .res_o   (lane_res[p])
    );
  end

  ssrsd_merge u_merge (
    .res_i    (lane_res),
    .number_i (cmd2_q == ssrsd_pkg::CMD_NUMBER),
    .neg_i    (neg2_q),
    .oor_i    (oor2_q),
    .seg_o    (new_seg)
  );

  always_comb begin
    relay_d    = relay_q;
    store_d    = store_q;
    pos_d      = pos_q;
    last_sel_d = last_sel_q;
    last_seg_d = last_seg_q;
    emit       = 1'b0;
    unique case (cmd2_q)
      ssrsd_pkg::CMD_SCAN: begin
        emit       = 1'b1;
        last_sel_d = '0;
        last_seg_d = '0;
        for (int i = 0; i < L; i++) begin
          if (32'(pos_q) == i) begin
            last_sel_d = sel_q[i];
            last_seg_d = store_q[i];
          end
        end
        if (32'(pos_q) >= ssrsd_pkg::DIGIT_COUNT - 1) begin
          pos_d = '0;
        end else begin
          pos_d = pos_q + ssrsd_pkg::POS_W'(1);
        end
      end
      ssrsd_pkg::CMD_RELAYS_ALL: begin
        emit    = 1'b1;
        relay_d = mask2_q;
      end
      ssrsd_pkg::CMD_RELAY_BIT: begin
        emit              = 1'b1;
        relay_d[index2_q] = level2_q;
      end
      ssrsd_pkg::CMD_TEXT, ssrsd_pkg::CMD_NUMBER: begin
        store_d = new_seg;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      relay_q     <= '0;
      pos_q       <= '0;
      last_sel_q  <= '0;
      last_seg_q  <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < L; i++) begin
        store_q[i] <= ssrsd_pkg::SEG_BLANK;
      end
    end else if (advance) begin
      out_valid_q <= v2_q && emit;
      if (v2_q) begin
        relay_q    <= relay_d;
        pos_q      <= pos_d;
        last_sel_q <= last_sel_d;
        last_seg_q <= last_seg_d;
        store_q    <= store_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_relays_q <= relay_d;
      out_sel_q    <= last_sel_d;
      out_seg_q    <= last_seg_d;
    end
  end

  // Index REG_RELAY_RESET_ALL_ON has no register behind it: a write to it is ignored,
  // so the relays always come out of reset off and a write to it changes nothing.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q[0] <= 8'd1;
      sel_q[1] <= 8'd2;
      sel_q[2] <= 8'd4;
      sel_q[3] <= 8'd8;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        ssrsd_pkg::REG_DIGIT_SELECT_FIRST:  sel_q[0] <= cfg_data_i;
        ssrsd_pkg::REG_DIGIT_SELECT_SECOND: sel_q[1] <= cfg_data_i;
        ssrsd_pkg::REG_DIGIT_SELECT_THIRD:  sel_q[2] <= cfg_data_i;
        ssrsd_pkg::REG_DIGIT_SELECT_FOURTH: sel_q[3] <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign out_valid_o          = out_valid_q;
  assign frame_relays_o       = out_relays_q;
  assign frame_digit_select_o = out_sel_q;
  assign frame_segments_o     = out_seg_q;

endmodule
